FILE: sv/ekd_pkg.sv
`timescale 1ns / 1ps
// ekd_pkg: shared types for the escape key decoder with cursor control.
// Holds the key codes, the request and configuration structs and register indexes.
// No dependencies.
package ekd_pkg;

   // Decoded key codes
   typedef enum logic [3:0] {
      KEY_NONE  = 4'd0,
      KEY_LEFT  = 4'd1,
      KEY_RIGHT = 4'd2,
      KEY_UP    = 4'd3,
      KEY_DOWN  = 4'd4,
      KEY_DEL   = 4'd5,
      KEY_PGUP  = 4'd6,
      KEY_PGDN  = 4'd7,
      KEY_HOME  = 4'd8,
      KEY_END   = 4'd9,
      KEY_ESC   = 4'd10,
      KEY_PLAIN = 4'd11,
      KEY_QUIT  = 4'd12
   } key_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SCREEN_ROWS = 2'd0,
      CSR_SCREEN_COLS = 2'd1,
      CSR_LINE_COUNT  = 2'd2
   } csr_index_type;

   // Request commands
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // Configuration register contents
   typedef struct packed {
      logic [7:0]  screen_rows;
      logic [7:0]  screen_cols;
      logic [15:0] line_count;
   } cfg_type;

   // One request as held in the input register
   typedef struct packed {
      logic       command;
      logic [7:0] byte_in;
   } req_type;

   localparam logic [7:0]  SCREEN_ROWS_RESET = 8'd24;
   localparam logic [7:0]  SCREEN_COLS_RESET = 8'd80;
   localparam logic [15:0] LINE_COUNT_RESET  = 16'd0;

endpackage

FILE: sv/ekd_decoder.sv
`timescale 1ns / 1ps
// ekd_decoder: escape sequence state machine, turns bytes and timeouts into keys.
// Depends on ekd_pkg.
module ekd_decoder
   import ekd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req,
   output key_type key
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_ESC   = 4'b0010,
      PH_SEQ   = 4'b0100,
      PH_TILDE = 4'b1000
   } phase_type;

   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_CTRL_Q  = 8'h11;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_O       = 8'h4F;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_B       = 8'h42;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_F       = 8'h46;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_1       = 8'h31;
   localparam logic [7:0] CH_3       = 8'h33;
   localparam logic [7:0] CH_4       = 8'h34;
   localparam logic [7:0] CH_5       = 8'h35;
   localparam logic [7:0] CH_6       = 8'h36;
   localparam logic [7:0] CH_7       = 8'h37;
   localparam logic [7:0] CH_8       = 8'h38;
   localparam logic [7:0] CH_9       = 8'h39;

   // Final letter of ESC [ letter
   function automatic key_type letter_key(input logic [7:0] b);
      key_type k;
      case (b)
         CH_A:    k = KEY_UP;
         CH_B:    k = KEY_DOWN;
         CH_C:    k = KEY_RIGHT;
         CH_D:    k = KEY_LEFT;
         CH_H:    k = KEY_HOME;
         CH_F:    k = KEY_END;
         default: k = KEY_ESC;
      endcase
      return k;
   endfunction

   // Digit of ESC [ digit ~
   function automatic key_type tilde_key(input logic [7:0] d);
      key_type k;
      case (d)
         CH_1, CH_7: k = KEY_HOME;
         CH_3:       k = KEY_DEL;
         CH_4, CH_8: k = KEY_END;
         CH_5:       k = KEY_PGUP;
         CH_6:       k = KEY_PGDN;
         default:    k = KEY_ESC;
      endcase
      return k;
   endfunction

   phase_type  phase_ff, phase_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;

   // Decode one request against the current phase
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      key       = KEY_NONE;
      if (req.command == CMD_TIMEOUT) begin
         if (phase_ff != PH_IDLE) begin
            key = KEY_ESC;
         end
         phase_in = PH_IDLE;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (req.byte_in == CH_ESC) begin
                  phase_in = PH_ESC;
               end else if (req.byte_in == CH_CTRL_Q) begin
                  key = KEY_QUIT;
               end else begin
                  key = KEY_PLAIN;
               end
            end
            PH_ESC: begin
               first_in = req.byte_in;
               phase_in = PH_SEQ;
            end
            PH_SEQ: begin
               second_in = req.byte_in;
               phase_in  = PH_IDLE;
               if (first_ff == CH_BRACKET) begin
                  if (req.byte_in inside {[CH_1:CH_9]}) begin
                     phase_in = PH_TILDE;
                  end else begin
                     key = letter_key(req.byte_in);
                  end
               end else if (first_ff == CH_O) begin
                  if (req.byte_in == CH_H) begin
                     key = KEY_HOME;
                  end else if (req.byte_in == CH_F) begin
                     key = KEY_END;
                  end else begin
                     key = KEY_ESC;
                  end
               end else begin
                  key = KEY_ESC;
               end
            end
            PH_TILDE: begin
               phase_in = PH_IDLE;
               key = (req.byte_in == CH_TILDE) ? tilde_key(second_ff) : KEY_ESC;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Advance the sequence state on each processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         first_ff  <= '0;
         second_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   // A timeout always drops back to idle
   a_timeout_idle: assert property (@(posedge clock) disable iff (reset)
      advance && req.command == CMD_TIMEOUT |=> phase_ff == PH_IDLE)
      else $error("decoder not idle after timeout");

   // An escape byte while idle opens a sequence and yields no key
   a_esc_opens: assert property (@(posedge clock) disable iff (reset)
      advance && req.command == CMD_BYTE && phase_ff == PH_IDLE && req.byte_in == CH_ESC
      |-> key == KEY_NONE ##1 phase_ff == PH_ESC)
      else $error("escape byte did not open a sequence");

endmodule

FILE: sv/ekd_cursor.sv
`timescale 1ns / 1ps
// ekd_cursor: clamped cursor movement and view scrolling driven by decoded keys.
// Depends on ekd_pkg.
module ekd_cursor
   import ekd_pkg::*;
#(
   parameter int COL_BITS  = 8,
   parameter int LINE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  key_type              key,
   input  cfg_type              cfg,
   output logic [COL_BITS-1:0]  col,
   output logic [LINE_BITS-1:0] line,
   output logic [LINE_BITS-1:0] view
);

   localparam int CW = (COL_BITS > 8) ? COL_BITS : 8;
   localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;

   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [LINE_BITS-1:0] view_ff, view_in;

   logic [7:0]           cols_m1;
   logic [CW-1:0]        col_lim_wide;
   logic [CW-1:0]        col_max_wide;
   logic [COL_BITS-1:0]  col_limit;
   logic [LW-1:0]        line_cnt_wide;
   logic [LW-1:0]        line_max_wide;
   logic [LINE_BITS-1:0] line_limit;
   logic [LINE_BITS-1:0] rows_ext;
   logic [LINE_BITS:0]   pgdn_sum;
   logic [LINE_BITS-1:0] view_min;
   logic [LINE_BITS:0]   view_end;

   // Clamp the column and line limits to the register widths
   always_comb begin
      cols_m1       = (cfg.screen_cols == 8'd0) ? 8'd0 : cfg.screen_cols - 8'd1;
      col_lim_wide  = CW'(cols_m1);
      col_max_wide  = CW'({COL_BITS{1'b1}});
      col_limit     = COL_BITS'((col_lim_wide > col_max_wide) ? col_max_wide : col_lim_wide);
      line_cnt_wide = LW'(cfg.line_count);
      line_max_wide = LW'({LINE_BITS{1'b1}});
      line_limit    = LINE_BITS'((line_cnt_wide > line_max_wide) ? line_max_wide
                                                                  : line_cnt_wide);
      rows_ext      = LINE_BITS'(cfg.screen_rows);
   end

   // Move the cursor for the key
   always_comb begin
      col_in   = col_ff;
      line_in  = line_ff;
      pgdn_sum = {1'b0, line_ff} + {1'b0, rows_ext};
      case (key)
         KEY_LEFT: begin
            if (col_ff != '0) col_in = col_ff - 1'b1;
         end
         KEY_RIGHT: begin
            if (col_ff < col_limit) col_in = col_ff + 1'b1;
         end
         KEY_UP: begin
            if (line_ff != '0) line_in = line_ff - 1'b1;
         end
         KEY_DOWN: begin
            if (line_ff < line_limit) line_in = line_ff + 1'b1;
         end
         KEY_HOME: begin
            col_in = '0;
         end
         KEY_END: begin
            col_in = col_limit;
         end
         KEY_PGUP: begin
            line_in = (line_ff >= rows_ext) ? line_ff - rows_ext : '0;
         end
         KEY_PGDN: begin
            if (line_ff < line_limit) begin
               line_in = (pgdn_sum > {1'b0, line_limit}) ? line_limit
                                                         : pgdn_sum[LINE_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Let the view top follow the new cursor line
   always_comb begin
      view_min = (line_in < view_ff) ? line_in : view_ff;
      view_end = {1'b0, view_min} + {1'b0, rows_ext};
      view_in  = view_min;
      if (cfg.screen_rows == 8'd0) begin
         view_in = line_in;
      end else if ({1'b0, line_in} >= view_end) begin
         view_in = line_in - rows_ext + 1'b1;
      end
   end

   // Hold the cursor and view between requests
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
         view_ff <= '0;
      end else if (advance) begin
         col_ff  <= col_in;
         line_ff <= line_in;
         view_ff <= view_in;
      end
   end

   assign col  = col_ff;
   assign line = line_ff;
   assign view = view_ff;

   // Keys without movement leave the cursor alone
   a_no_move: assert property (@(posedge clock) disable iff (reset)
      advance && (key == KEY_NONE || key == KEY_DEL || key == KEY_ESC ||
                  key == KEY_PLAIN || key == KEY_QUIT)
      |=> $stable(col_ff) && $stable(line_ff))
      else $error("cursor moved on a non-moving key");

   // With nonzero screen rows, the cursor line always lies inside the view window
   a_in_view: assert property (@(posedge clock) disable iff (reset)
      advance && cfg.screen_rows != 8'd0
      |=> view_ff <= line_ff &&
          {1'b0, line_ff} < {1'b0, view_ff} + {1'b0, LINE_BITS'($past(cfg.screen_rows))})
      else $error("cursor line outside the view");

endmodule

FILE: sv/escape_key_decoder_cursor_control_top.sv
`timescale 1ns / 1ps
// escape_key_decoder_cursor_control_top: input register, decoder, cursor logic, result register.
// Depends on ekd_pkg, ekd_decoder and ekd_cursor.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_command, req_byte_in
//   rsp      out        rsp_valid/rsp_ready  rsp_key_code, rsp_cursor_col, rsp_cursor_line,
//                                            rsp_view_top, rsp_quit
//   csr      in         csr_write_en         csr_index, csr_write_data
//
// One request per cycle while the result side is not stalled; a request's result passes
// through the input register, then decode and cursor update into the result register.
// Reset returns the decoder to idle, the cursor and view to zero and the
// registers to 24 rows, 80 columns, 0 lines. A stalled result holds the input
// register, which still takes one more request before req_ready drops.
module escape_key_decoder_cursor_control_top
   import ekd_pkg::*;
#(
   parameter int COL_BITS  = 8,
   parameter int LINE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic [7:0]           req_byte_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_key_code,
   output logic [COL_BITS-1:0]  rsp_cursor_col,
   output logic [LINE_BITS-1:0] rsp_cursor_line,
   output logic [LINE_BITS-1:0] rsp_view_top,
   output logic                 rsp_quit,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_write_data
);

   cfg_type cfg_ff;
   logic    in_valid_ff;
   req_type in_req_ff;
   logic    out_valid_ff;
   key_type out_key_ff;
   logic    out_free;
   logic    advance;
   key_type key;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_rows <= SCREEN_ROWS_RESET;
         cfg_ff.screen_cols <= SCREEN_COLS_RESET;
         cfg_ff.line_count  <= LINE_COUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCREEN_ROWS: cfg_ff.screen_rows <= csr_write_data[7:0];
            CSR_SCREEN_COLS: cfg_ff.screen_cols <= csr_write_data[7:0];
            CSR_LINE_COUNT:  cfg_ff.line_count  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Pipeline handshake
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_req_ff.command <= req_command;
         in_req_ff.byte_in <= req_byte_in;
      end
   end

   ekd_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_req_ff),
      .key     (key)
   );

   ekd_cursor #(
      .COL_BITS  (COL_BITS),
      .LINE_BITS (LINE_BITS)
   ) u_cursor (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .key     (key),
      .cfg     (cfg_ff),
      .col     (rsp_cursor_col),
      .line    (rsp_cursor_line),
      .view    (rsp_view_top)
   );

   // Result register; cursor fields live in the cursor block and update with it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_key_ff <= key;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_key_code = out_key_ff;
   assign rsp_quit     = (out_key_ff == KEY_QUIT);

   // A full pipe with a stalled result must refuse new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request accepted into a full pipe");

endmodule

FILE: tb/escape_key_decoder_cursor_control_top_tb.sv
`timescale 1ns / 1ps
// escape_key_decoder_cursor_control_top_tb: self-checking bench for the escape key decoder.
// Feeds terminal bytes and timeout ticks, predicts key, cursor, view top and quit per request.
// Depends on ekd_pkg and escape_key_decoder_cursor_control_top.
module escape_key_decoder_cursor_control_top_tb;
   import ekd_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [7:0] ESC_BYTE    = 8'h1b;
   localparam logic [7:0] CTRL_Q_BYTE = 8'h11;
   localparam logic [7:0] CSI_BYTE    = "[";
   localparam logic [7:0] SS3_BYTE    = "O";
   localparam logic [7:0] TILDE_BYTE  = "~";
   // Final letters of cursor sequences and digits of tilde sequences
   localparam logic [47:0] CSI_LETTERS  = "ABCDHF";
   localparam logic [71:0] TILDE_DIGITS = "123456789";

   typedef enum logic [3:0] {
      SEQ_IDLE  = 4'b0001,
      SEQ_ESC   = 4'b0010,
      SEQ_INTRO = 4'b0100,
      SEQ_DIGIT = 4'b1000
   } seq_state_type;

   typedef struct {
      key_type     key;
      logic [7:0]  col;
      logic [15:0] line;
      logic [15:0] top;
      logic        quit;
   } cursor_result_type;

   // DUT ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_BYTE;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_key_code;
   logic [7:0]  rsp_cursor_col;
   logic [15:0] rsp_cursor_line;
   logic [15:0] rsp_view_top;
   logic        rsp_quit;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = CSR_SCREEN_ROWS;
   logic [15:0] csr_write_data = 16'h0000;

   // Predicted decoder, cursor and register state
   seq_state_type seq_state = SEQ_IDLE;
   logic [7:0]  seq_intro = 8'h00;
   logic [7:0]  seq_param = 8'h00;
   logic [7:0]  col_pos = 8'h00;
   logic [15:0] line_pos = 16'h0000;
   logic [15:0] top_line = 16'h0000;
   logic [7:0]  rows_cfg = SCREEN_ROWS_RESET;
   logic [7:0]  cols_cfg = SCREEN_COLS_RESET;
   logic [15:0] lines_cfg = LINE_COUNT_RESET;

   req_type           pending_requests[$];
   cursor_result_type expected_keys[$];
   cursor_result_type want;

   // Handshake bookkeeping between the edge processes
   bit      req_accepted = 1'b0;
   bit      rsp_accepted = 1'b0;
   bit      sender_next_valid;
   req_type sender_item;
   int      sender_gap = 0;
   int      receiver_wait = 0;
   int      receiver_holdoff = 0;
   bit      sender_gaps_on = 1'b1;
   bit      receiver_stalls_on = 1'b1;

   int mismatch_count = 0;
   int cycle_count = 0;

   escape_key_decoder_cursor_control_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_code    (rsp_key_code),
      .rsp_cursor_col  (rsp_cursor_col),
      .rsp_cursor_line (rsp_cursor_line),
      .rsp_view_top    (rsp_view_top),
      .rsp_quit        (rsp_quit),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // Generate the clock
   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Decode one request, move the cursor, scroll the view and queue the expected result
   task automatic predict_key_and_cursor(input req_type rq);
      key_type           key;
      int unsigned       col_limit;
      int unsigned       line_limit;
      int unsigned       col_u;
      int unsigned       line_u;
      int unsigned       top_u;
      int unsigned       rows_u;
      cursor_result_type res;
      key = KEY_NONE;
      if (rq.command == CMD_TIMEOUT) begin
         if (seq_state != SEQ_IDLE) key = KEY_ESC;
         seq_state = SEQ_IDLE;
      end else begin
         case (seq_state)
            SEQ_IDLE: begin
               if (rq.byte_in == ESC_BYTE) seq_state = SEQ_ESC;
               else if (rq.byte_in == CTRL_Q_BYTE) key = KEY_QUIT;
               else key = KEY_PLAIN;
            end
            SEQ_ESC: begin
               seq_intro = rq.byte_in;
               seq_state = SEQ_INTRO;
            end
            SEQ_INTRO: begin
               seq_param = rq.byte_in;
               seq_state = SEQ_IDLE;
               if (seq_intro == CSI_BYTE) begin
                  if (rq.byte_in > "0" && rq.byte_in <= "9") begin
                     seq_state = SEQ_DIGIT;
                  end else begin
                     case (rq.byte_in)
                        "A":     key = KEY_UP;
                        "B":     key = KEY_DOWN;
                        "C":     key = KEY_RIGHT;
                        "D":     key = KEY_LEFT;
                        "H":     key = KEY_HOME;
                        "F":     key = KEY_END;
                        default: key = KEY_ESC;
                     endcase
                  end
               end else if (seq_intro == SS3_BYTE) begin
                  if (rq.byte_in == "H") key = KEY_HOME;
                  else if (rq.byte_in == "F") key = KEY_END;
                  else key = KEY_ESC;
               end else begin
                  key = KEY_ESC;
               end
            end
            default: begin
               seq_state = SEQ_IDLE;
               if (rq.byte_in != TILDE_BYTE) begin
                  key = KEY_ESC;
               end else begin
                  case (seq_param)
                     "1", "7": key = KEY_HOME;
                     "3":      key = KEY_DEL;
                     "4", "8": key = KEY_END;
                     "5":      key = KEY_PGUP;
                     "6":      key = KEY_PGDN;
                     default:  key = KEY_ESC;
                  endcase
               end
            end
         endcase
      end

      // Move the cursor within the screen and text limits
      col_limit  = (cols_cfg == 8'd0) ? 0 : 32'(cols_cfg) - 1;
      line_limit = 32'(lines_cfg);
      col_u      = 32'(col_pos);
      line_u     = 32'(line_pos);
      top_u      = 32'(top_line);
      rows_u     = 32'(rows_cfg);
      case (key)
         KEY_LEFT:  if (col_u != 0) col_u = col_u - 1;
         KEY_RIGHT: if (col_u < col_limit) col_u = col_u + 1;
         KEY_UP:    if (line_u != 0) line_u = line_u - 1;
         KEY_DOWN:  if (line_u < line_limit) line_u = line_u + 1;
         KEY_HOME:  col_u = 0;
         KEY_END:   col_u = col_limit;
         KEY_PGUP:  line_u = (line_u >= rows_u) ? line_u - rows_u : 0;
         KEY_PGDN: begin
            if (line_u < line_limit) begin
               line_u = line_u + rows_u;
               if (line_u > line_limit) line_u = line_limit;
            end
         end
         default: ;
      endcase

      // Keep the cursor line inside the view
      if (line_u < top_u) top_u = line_u;
      if (rows_u == 0) top_u = line_u;
      else if (line_u >= top_u + rows_u) top_u = line_u - rows_u + 1;

      col_pos  = col_u[7:0];
      line_pos = line_u[15:0];
      top_line = top_u[15:0];
      res.key  = key;
      res.col  = col_pos;
      res.line = line_pos;
      res.top  = top_line;
      res.quit = (key == KEY_QUIT);
      expected_keys.push_back(res);
   endtask

   // Track acceptances, predict on each request, check each result
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_accepted = 1'b1;
            if (expected_keys.size() == 0) begin
               $error("result with no request outstanding: key_code %0d", rsp_key_code);
               mismatch_count++;
            end else begin
               want = expected_keys.pop_front();
               if (rsp_key_code !== want.key) begin
                  $error("key_code: expected %0d, got %0d", want.key, rsp_key_code);
                  mismatch_count++;
               end
               if (rsp_cursor_col !== want.col) begin
                  $error("cursor_col: expected %0d, got %0d", want.col, rsp_cursor_col);
                  mismatch_count++;
               end
               if (rsp_cursor_line !== want.line) begin
                  $error("cursor_line: expected %0d, got %0d", want.line, rsp_cursor_line);
                  mismatch_count++;
               end
               if (rsp_view_top !== want.top) begin
                  $error("view_top: expected %0d, got %0d", want.top, rsp_view_top);
                  mismatch_count++;
               end
               if (rsp_quit !== want.quit) begin
                  $error("quit: expected %0d, got %0d", want.quit, rsp_quit);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_accepted = 1'b1;
            predict_key_and_cursor('{command: req_command, byte_in: req_byte_in});
         end
      end
   end

   // Offer pending requests, holding each until accepted, with random gaps
   always @(negedge clock) begin
      if (!reset) begin
         sender_next_valid = req_valid;
         if (req_valid && req_accepted) sender_next_valid = 1'b0;
         req_accepted = 1'b0;
         if (!sender_next_valid) begin
            if (sender_gap > 0) begin
               sender_gap--;
            end else if (pending_requests.size() != 0) begin
               sender_item = pending_requests.pop_front();
               req_command <= sender_item.command;
               req_byte_in <= sender_item.byte_in;
               sender_next_valid = 1'b1;
               sender_gap = sender_gaps_on ? $urandom_range(0, 5) : 0;
            end
         end
         req_valid <= sender_next_valid;
      end
   end

   // Stall the result side: long hold-offs on request, random waits per result
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_accepted) begin
            receiver_wait = receiver_stalls_on ? $urandom_range(0, 5) : 0;
            rsp_accepted = 1'b0;
         end
         if (receiver_holdoff > 0) begin
            receiver_holdoff--;
            rsp_ready <= 1'b0;
         end else if (receiver_wait > 0) begin
            receiver_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_request(input logic cmd, input logic [7:0] data);
      pending_requests.push_back('{command: cmd, byte_in: data});
   endtask

   // ESC [ letter
   task automatic queue_csi(input logic [7:0] letter);
      queue_request(CMD_BYTE, ESC_BYTE);
      queue_request(CMD_BYTE, CSI_BYTE);
      queue_request(CMD_BYTE, letter);
   endtask

   // ESC [ digit ~
   task automatic queue_tilde(input logic [7:0] digit);
      queue_csi(digit);
      queue_request(CMD_BYTE, TILDE_BYTE);
   endtask

   // Block until every request went through and every result came back
   task automatic wait_for_drain;
      while (pending_requests.size() != 0 || req_valid || expected_keys.size() != 0)
         @(posedge clock);
   endtask

   // Write all three registers while the block is idle
   task automatic set_geometry(input int rows, input int cols, input int lines);
      logic [7:0] junk;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      junk = 8'($urandom_range(0, 255));
      csr_write_en   = 1'b1;
      csr_index      = CSR_SCREEN_ROWS;
      csr_write_data = {junk, rows[7:0]};
      rows_cfg       = rows[7:0];
      @(negedge clock);
      junk = 8'($urandom_range(0, 255));
      csr_index      = CSR_SCREEN_COLS;
      csr_write_data = {junk, cols[7:0]};
      cols_cfg       = cols[7:0];
      @(negedge clock);
      csr_index      = CSR_LINE_COUNT;
      csr_write_data = lines[15:0];
      lines_cfg      = lines[15:0];
      @(negedge clock);
      csr_write_en   = 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed key sequences, the rest plain bytes, broken sequences and timeouts
   task automatic queue_random_keys(input int count);
      int         pushed;
      int         pick;
      int         extra;
      logic [7:0] digit;
      pushed = 0;
      while (pushed < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            queue_csi(CSI_LETTERS[8 * $urandom_range(0, 5) +: 8]);
            pushed += 3;
         end else if (pick < 62) begin
            // favor the known digits, sometimes an unknown one
            if ($urandom_range(0, 9) == 0) digit = TILDE_DIGITS[8 * $urandom_range(0, 8) +: 8];
            else digit = ($urandom_range(0, 1) == 0) ? "6" : "5";
            if ($urandom_range(0, 2) == 0) digit = TILDE_DIGITS[8 * $urandom_range(0, 8) +: 8];
            queue_tilde(digit);
            pushed += 4;
         end else if (pick < 68) begin
            queue_request(CMD_BYTE, ESC_BYTE);
            queue_request(CMD_BYTE, SS3_BYTE);
            if ($urandom_range(0, 3) == 0) queue_request(CMD_BYTE, 8'($urandom_range(0, 255)));
            else queue_request(CMD_BYTE, ($urandom_range(0, 1) == 0) ? "H" : "F");
            pushed += 3;
         end else if (pick < 82) begin
            if ($urandom_range(0, 4) == 0) queue_request(CMD_BYTE, CTRL_Q_BYTE);
            else queue_request(CMD_BYTE, 8'($urandom_range(0, 255)));
            pushed += 1;
         end else if (pick < 92) begin
            // broken sequence: escape, some random bytes, maybe a timeout
            queue_request(CMD_BYTE, ESC_BYTE);
            extra = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 0) begin
               queue_request(CMD_BYTE, CSI_BYTE);
               extra++;
            end
            repeat (extra) queue_request(CMD_BYTE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) begin
               queue_request(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
               extra++;
            end
            pushed += extra + 1;
         end else begin
            queue_request(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
            pushed += 1;
         end
      end
   endtask

   task automatic run_phase(input int rows, input int cols, input int lines,
                            input bit gaps, input bit stalls, input int count);
      set_geometry(rows, cols, lines);
      sender_gaps_on     = gaps;
      receiver_stalls_on = stalls;
      queue_random_keys(count);
   endtask

   // Reset, directed checks, then random phases across several geometries
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      set_geometry(10, 40, 300);
      queue_request(CMD_BYTE, 8'h00);
      queue_request(CMD_BYTE, 8'hff);
      queue_request(CMD_BYTE, CTRL_Q_BYTE);
      queue_request(CMD_TIMEOUT, 8'ha5);
      queue_csi("C");
      queue_tilde("6");
      queue_request(CMD_BYTE, ESC_BYTE);
      queue_request(CMD_BYTE, SS3_BYTE);
      queue_request(CMD_BYTE, "F");
      queue_tilde("2");
      queue_request(CMD_BYTE, ESC_BYTE);
      queue_request(CMD_TIMEOUT, 8'h5a);
      queue_request(CMD_BYTE, ESC_BYTE);
      queue_request(CMD_BYTE, CSI_BYTE);
      queue_request(CMD_TIMEOUT, 8'h00);
      queue_request(CMD_BYTE, ESC_BYTE);
      queue_request(CMD_BYTE, "x");
      queue_request(CMD_BYTE, "y");
      queue_csi("7");
      queue_request(CMD_BYTE, "q");

      // Hold the result side off so the block fills and stalls its input
      run_phase(10, 40, 300, 1'b1, 1'b1, 220);
      receiver_holdoff = 150;

      run_phase(0, 0, 0, 1'b0, 1'b0, 200);
      run_phase(255, 255, 65535, 1'b1, 1'b0, 200);
      run_phase(1, 1, 5, 1'b0, 1'b1, 200);

      // Pause the sender midway until every result is back, then stall again
      run_phase(24, 80, 2000, 1'b1, 1'b1, 100);
      wait_for_drain();
      receiver_holdoff = 80;
      queue_random_keys(100);
      // Park the cursor far right and low before the limits shrink
      queue_csi("F");
      repeat (3) queue_tilde("6");

      run_phase(3, 6, 4, 1'b1, 1'b1, 150);
      run_phase($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 600),
                1'b1, 1'b1, 150);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: escape_key_decoder_cursor_control_top.f
sv/ekd_pkg.sv
sv/ekd_decoder.sv
sv/ekd_cursor.sv
sv/escape_key_decoder_cursor_control_top.sv
tb/escape_key_decoder_cursor_control_top_tb.sv
